[rtl/tcw_pkg.sv]
// shared types, codes and helpers for the text console writer
package tcw_pkg;

	// item modes
	localparam logic [1:0] MODE_PUT   = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// special character codes
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] TAB_STEP   = 8'd4;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_SCROLL = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_CLEAR  = 5'b10000
	} tcw_state_t;

	// add with saturation at 255
	function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [7:0] d);
		logic [8:0] s;
		s = {1'b0, v} + {1'b0, d};
		return s[8] ? 8'hFF : s[7:0];
	endfunction

endpackage

[rtl/text_console_writer_core.sv]
// text console writer: screen cell memory, cursor and scroll/clear sequencer
// put character: result in the next cycle, no busy, unless a scroll is needed;
// read cell: memory read port, then result register. scroll: busy through the row copy
// and blank, one cell per cycle. clear item: result in the next cycle, then busy while
// the memory is cleared. after reset a clearing pass runs with busy high.
// the receiver cannot stall: each result is shown with done for one cycle.
module text_console_writer_core import tcw_pkg::*; #(
	parameter int ROWS    = 25,
	parameter int COLUMNS = 80
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] mode,
	input  logic [7:0] char_code,
	input  logic [7:0] color,
	input  logic [4:0] read_row,
	input  logic [6:0] read_col,
	output logic       done,
	output logic [15:0] cell_value,
	output logic [4:0] cell_row,
	output logic [6:0] cell_col,
	output logic       cell_valid,
	output logic       scrolled,
	output logic [7:0] cursor_row,
	output logic [7:0] cursor_col
);

	localparam int NCELLS = ROWS * COLUMNS;
	localparam int AW = $clog2(NCELLS);
	localparam logic [AW-1:0] BASE = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] LAST = AW'(NCELLS - 1);
	localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

	tcw_state_t state_q;
	logic [7:0] cur_row_q, cur_col_q;
	logic [AW-1:0] ptr_q;
	logic put_q;
	logic [15:0] pend_q;

	// screen memory and its ports
	logic [15:0] mem [NCELLS];
	logic [15:0] rd_q;
	logic re;
	logic [AW-1:0] raddr;
	logic we;
	logic [AW-1:0] waddr;
	logic [15:0] wdata;

	// copy pipeline stage
	logic wr_en_s1;
	logic [AW-1:0] wr_addr_s1;

	// output registers
	logic done_q, valid_q, scr_q;
	logic [15:0] value_q;
	logic [4:0] crow_q;
	logic [6:0] ccol_q;

	logic accept;
	logic is_put, is_nl, is_tab, is_char;
	logic wrap, need_scroll;
	logic [7:0] row_w, col_w, row_p, col_p;
	logic [AW-1:0] put_addr, rd_addr_in;
	logic rd_ok;
	logic [15:0] put_value;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);

	// decode of the put character path
	always_comb begin
		is_put  = (mode == MODE_PUT);
		is_nl   = is_put && (char_code == CH_NEWLINE);
		is_tab  = is_put && (char_code == CH_TAB);
		is_char = is_put && !is_nl && !is_tab;
		wrap    = (cur_col_q >= 8'(COLUMNS - 1));
		row_w   = wrap ? sat_add(cur_row_q, 8'd1) : cur_row_q;
		col_w   = wrap ? 8'd0 : cur_col_q;
		need_scroll = (row_w >= 8'(ROWS));
		row_p   = need_scroll ? 8'(ROWS - 1) : row_w;
		col_p   = need_scroll ? 8'd0 : col_w;
		put_addr  = AW'(row_p) * COLS_A + AW'(col_p);
		put_value = {color, char_code};
		rd_ok   = ({2'b00, read_row} < 7'(ROWS)) && ({1'b0, read_col} < 8'(COLUMNS));
		rd_addr_in = AW'(read_row) * COLS_A + AW'(read_col);
	end

	// read port select
	always_comb begin
		re = 1'b0;
		raddr = ptr_q;
		if (state_q == ST_SCROLL) begin
			re = 1'b1;
		end else if (accept && mode == MODE_READ && rd_ok) begin
			re = 1'b1;
			raddr = rd_addr_in;
		end
	end

	// write port select
	always_comb begin
		we = 1'b0;
		waddr = ptr_q;
		wdata = 16'd0;
		if (wr_en_s1) begin
			we = 1'b1;
			waddr = wr_addr_s1;
			wdata = rd_q;
		end else if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wdata = (put_q && ptr_q == BASE) ? pend_q : 16'd0;
		end else if (accept && is_char && !need_scroll) begin
			we = 1'b1;
			waddr = put_addr;
			wdata = put_value;
		end
	end

	// memory access
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// copy stage tracks the read issued in the scroll state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= (state_q == ST_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1 <= ptr_q - COLS_A;
	end

	// sequencer, cursor and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			ptr_q     <= '0;
			put_q     <= 1'b0;
			pend_q    <= 16'd0;
			cur_row_q <= 8'd0;
			cur_col_q <= 8'd0;
			done_q    <= 1'b0;
			valid_q   <= 1'b0;
			scr_q     <= 1'b0;
			value_q   <= 16'd0;
			crow_q    <= 5'd0;
			ccol_q    <= 7'd0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						valid_q <= 1'b0;
						scr_q   <= 1'b0;
						value_q <= 16'd0;
						crow_q  <= 5'd0;
						ccol_q  <= 7'd0;
						case (mode)
							MODE_PUT: begin
								if (is_nl) begin
									cur_col_q <= 8'd0;
									cur_row_q <= sat_add(cur_row_q, 8'd1);
									done_q    <= 1'b1;
								end else if (is_tab) begin
									cur_col_q <= sat_add(cur_col_q, TAB_STEP);
									done_q    <= 1'b1;
								end else begin
									cur_row_q <= row_p;
									cur_col_q <= sat_add(col_p, 8'd1);
									pend_q    <= put_value;
									if (need_scroll) begin
										put_q   <= 1'b1;
										ptr_q   <= COLS_A;
										state_q <= ST_SCROLL;
									end else begin
										valid_q <= 1'b1;
										value_q <= put_value;
										crow_q  <= row_p[4:0];
										ccol_q  <= col_p[6:0];
										done_q  <= 1'b1;
									end
								end
							end
							MODE_CLEAR: begin
								cur_row_q <= 8'd0;
								cur_col_q <= 8'd0;
								put_q     <= 1'b0;
								ptr_q     <= '0;
								done_q    <= 1'b1;
								state_q   <= ST_CLEAR;
							end
							MODE_READ: begin
								if (rd_ok) begin
									crow_q  <= read_row;
									ccol_q  <= read_col;
									state_q <= ST_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				ST_READ: begin
					value_q <= rd_q;
					valid_q <= 1'b1;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					if (ptr_q == LAST) begin
						state_q <= ST_DRAIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					ptr_q   <= BASE;
					state_q <= ST_CLEAR;
				end
				ST_CLEAR: begin
					if (ptr_q == LAST) begin
						state_q <= ST_IDLE;
						if (put_q) begin
							put_q   <= 1'b0;
							valid_q <= 1'b1;
							scr_q   <= 1'b1;
							value_q <= pend_q;
							crow_q  <= 5'(ROWS - 1);
							ccol_q  <= 7'd0;
							done_q  <= 1'b1;
						end
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign cell_value = value_q;
	assign cell_row   = crow_q;
	assign cell_col   = ccol_q;
	assign cell_valid = valid_q;
	assign scrolled   = scr_q;
	assign cursor_row = cur_row_q;
	assign cursor_col = cur_col_q;

endmodule

[tb/sv/tb.sv]
// testbench for the text console writer: directed table, random item bursts, shadow screen
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam int ROWS = 25;
	localparam int COLUMNS = 80;
	localparam int NCELLS = ROWS * COLUMNS;
	localparam int RANDOM_ITEMS = 430;
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// one input item and one result, at the port widths
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] char_code;
		logic [7:0] color;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} console_item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [4:0]  cell_row;
		logic [6:0]  cell_col;
		logic        cell_valid;
		logic        scrolled;
		logic [7:0]  cursor_row;
		logic [7:0]  cursor_col;
	} cell_result_t;

	typedef struct packed {
		console_item_t item;
		logic          has_want;
		cell_result_t  want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] mode = MODE_PUT;
	logic [7:0] char_code = 8'h00;
	logic [7:0] color = 8'h00;
	logic [4:0] read_row = 5'd0;
	logic [6:0] read_col = 7'd0;
	logic busy;
	logic done;
	logic [15:0] cell_value;
	logic [4:0] cell_row;
	logic [6:0] cell_col;
	logic cell_valid;
	logic scrolled;
	logic [7:0] cursor_row;
	logic [7:0] cursor_col;

	text_console_writer_core #(
		.ROWS(ROWS),
		.COLUMNS(COLUMNS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.char_code(char_code),
		.color(color),
		.read_row(read_row),
		.read_col(read_col),
		.done(done),
		.cell_value(cell_value),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.cell_valid(cell_valid),
		.scrolled(scrolled),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col)
	);

	// shadow copy of the screen and cursor
	logic [15:0] shadow_screen [NCELLS];
	logic [7:0] shadow_row;
	logic [7:0] shadow_col;

	cell_result_t pending_cells [$];
	int mismatch_count = 0;
	int items_sent = 0;
	bit steady = 1'b0;

	// directed items: fixed results where they are obvious, the rest predicted
	localparam int DIR_N = 20;
	directed_row_t directed_rows [DIR_N] = '{
		// reads right after reset: corners, then out of range
		'{'{MODE_READ, 8'h00, 8'h00, 5'd0, 7'd0}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b1, 1'b0, 8'd0, 8'd0}},
		'{'{MODE_READ, 8'hFF, 8'hFF, 5'd24, 7'd79}, 1'b1,
			'{16'h0000, 5'd24, 7'd79, 1'b1, 1'b0, 8'd0, 8'd0}},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd25, 7'd0}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0, 8'd0, 8'd0}},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd31, 7'd127}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0, 8'd0, 8'd0}},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd0, 7'd80}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0, 8'd0, 8'd0}},
		// zero byte is printable, then all-ones byte and color
		'{'{MODE_PUT, 8'h00, 8'h00, 5'd31, 7'd127}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b1, 1'b0, 8'd0, 8'd1}},
		'{'{MODE_PUT, 8'hFF, 8'hFF, 5'd0, 7'd0}, 1'b1,
			'{16'hFFFF, 5'd0, 7'd1, 1'b1, 1'b0, 8'd0, 8'd2}},
		// unused mode leaves everything alone
		'{'{MODE_NOP, 8'h5A, 8'hA5, 5'd21, 7'd42}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0, 8'd0, 8'd2}},
		// newline and tab write no cell
		'{'{MODE_PUT, CH_NEWLINE, 8'h7F, 5'd10, 7'd85}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0, 8'd1, 8'd0}},
		'{'{MODE_PUT, CH_TAB, 8'h80, 5'd5, 7'd42}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0, 8'd1, 8'd4}},
		'{'{MODE_PUT, 8'h41, 8'h1E, 5'd0, 7'd0}, 1'b1,
			'{16'h1E41, 5'd1, 7'd4, 1'b1, 1'b0, 8'd1, 8'd5}},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd1, 7'd4}, 1'b1,
			'{16'h1E41, 5'd1, 7'd4, 1'b1, 1'b0, 8'd1, 8'd5}},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd0, 7'd1}, 1'b1,
			'{16'hFFFF, 5'd0, 7'd1, 1'b1, 1'b0, 8'd1, 8'd5}},
		// clear wipes cells and cursor
		'{'{MODE_CLEAR, 8'h41, 8'h1E, 5'd1, 7'd4}, 1'b1,
			'{16'h0000, 5'd0, 7'd0, 1'b0, 1'b0, 8'd0, 8'd0}},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd0, 7'd1}, 1'b1,
			'{16'h0000, 5'd0, 7'd1, 1'b1, 1'b0, 8'd0, 8'd0}},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd1, 7'd4}, 1'b1,
			'{16'h0000, 5'd1, 7'd4, 1'b1, 1'b0, 8'd0, 8'd0}},
		// short line of text, checked against the shadow screen
		'{'{MODE_PUT, CH_SPACE, 8'h07, 5'd3, 7'd3}, 1'b0, '0},
		'{'{MODE_PUT, CH_NEWLINE, 8'h00, 5'd0, 7'd0}, 1'b0, '0},
		'{'{MODE_PUT, 8'h7E, 8'h70, 5'd0, 7'd0}, 1'b0, '0},
		'{'{MODE_READ, 8'h00, 8'h00, 5'd1, 7'd0}, 1'b0, '0}
	};

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// cursor increment that sticks at 255
	function automatic logic [7:0] cursor_bump(input logic [7:0] v, input logic [7:0] d);
		if (v > 8'd255 - d) begin
			return 8'hFF;
		end
		return v + d;
	endfunction

	// predict one item against the shadow screen and update it
	function automatic cell_result_t console_model(input console_item_t it);
		cell_result_t r;
		int idx;
		r = '0;
		case (it.mode)
			MODE_PUT: begin
				if (it.char_code == CH_NEWLINE) begin
					shadow_col = 8'd0;
					shadow_row = cursor_bump(shadow_row, 8'd1);
				end else if (it.char_code == CH_TAB) begin
					shadow_col = cursor_bump(shadow_col, TAB_STEP);
				end else begin
					// wrap at the last column
					if (shadow_col >= COLUMNS - 1) begin
						shadow_col = 8'd0;
						shadow_row = cursor_bump(shadow_row, 8'd1);
					end
					// scroll up one row when past the bottom
					if (shadow_row >= ROWS) begin
						for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
							shadow_screen[i] = shadow_screen[i + COLUMNS];
						end
						for (int i = (ROWS - 1) * COLUMNS; i < NCELLS; i++) begin
							shadow_screen[i] = 16'h0000;
						end
						shadow_col = 8'd0;
						shadow_row = 8'(ROWS - 1);
						r.scrolled = 1'b1;
					end
					idx = shadow_row * COLUMNS + shadow_col;
					shadow_screen[idx] = {it.color, it.char_code};
					r.cell_value = {it.color, it.char_code};
					r.cell_row = shadow_row[4:0];
					r.cell_col = shadow_col[6:0];
					r.cell_valid = 1'b1;
					shadow_col = cursor_bump(shadow_col, 8'd1);
				end
			end
			MODE_CLEAR: begin
				for (int i = 0; i < NCELLS; i++) begin
					shadow_screen[i] = 16'h0000;
				end
				shadow_row = 8'd0;
				shadow_col = 8'd0;
			end
			MODE_READ: begin
				if (it.read_row < ROWS && it.read_col < COLUMNS) begin
					r.cell_value = shadow_screen[it.read_row * COLUMNS + it.read_col];
					r.cell_row = it.read_row;
					r.cell_col = it.read_col;
					r.cell_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.cursor_row = shadow_row;
		r.cursor_col = shadow_col;
		return r;
	endfunction

	// idle cycles between items: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 19);
		if (steady || roll < 10) begin
			return 0;
		end
		if (roll < 18) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 50);
	endfunction

	// item with every field random
	function automatic console_item_t noise_item();
		console_item_t it;
		it.mode = 2'($urandom_range(0, 3));
		it.char_code = 8'($urandom_range(0, 255));
		it.color = 8'($urandom_range(0, 255));
		it.read_row = 5'($urandom_range(0, 31));
		it.read_col = 7'($urandom_range(0, 127));
		return it;
	endfunction

	// drive one item, wait for it to be taken, record its expected result
	task automatic send_item(input console_item_t it, input logic has_want,
			input cell_result_t want);
		cell_result_t predicted;
		int gap;
		start <= 1'b1;
		mode <= it.mode;
		char_code <= it.char_code;
		color <= it.color;
		read_row <= it.read_row;
		read_col <= it.read_col;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = console_model(it);
		pending_cells.push_back(has_want ? want : predicted);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random(input console_item_t it);
		send_item(it, 1'b0, '0);
	endtask

	// printable bytes only, so long runs wrap and scroll
	task automatic text_run(input int len);
		console_item_t it;
		repeat (len) begin
			it = noise_item();
			it.mode = MODE_PUT;
			if (it.char_code == CH_NEWLINE || it.char_code == CH_TAB) begin
				it.char_code = it.char_code ^ 8'h40;
			end
			send_random(it);
		end
	endtask

	task automatic control_run(input logic [7:0] code, input int len);
		console_item_t it;
		repeat (len) begin
			it = noise_item();
			it.mode = MODE_PUT;
			it.char_code = code;
			send_random(it);
		end
	endtask

	// stimulus
	initial begin
		console_item_t it;
		bit swept;
		int kind;
		swept = 1'b0;
		for (int i = 0; i < NCELLS; i++) begin
			shadow_screen[i] = 16'h0000;
		end
		shadow_row = 8'd0;
		shadow_col = 8'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_N; i++) begin
			send_item(directed_rows[i].item, directed_rows[i].has_want,
				directed_rows[i].want);
		end

		// random bursts of text, control bytes, reads and clears
		while (items_sent < DIR_N + RANDOM_ITEMS) begin
			steady = ($urandom_range(0, 3) == 0);
			if (!swept && items_sent > DIR_N + 60) begin
				// drive both cursor counters into saturation, then print
				control_run(CH_NEWLINE, $urandom_range(256, 262));
				control_run(CH_TAB, $urandom_range(64, 70));
				text_run(3);
				swept = 1'b1;
			end else begin
				kind = $urandom_range(0, 19);
				if (kind < 8) begin
					text_run(($urandom_range(0, 4) == 0) ? $urandom_range(60, 100)
						: $urandom_range(1, 12));
				end else if (kind < 11) begin
					control_run(CH_NEWLINE, ($urandom_range(0, 5) == 0)
						? $urandom_range(10, 30) : $urandom_range(1, 4));
				end else if (kind < 13) begin
					control_run(CH_TAB, ($urandom_range(0, 5) == 0)
						? $urandom_range(15, 25) : $urandom_range(1, 6));
				end else if (kind < 16) begin
					repeat ($urandom_range(1, 4)) begin
						it = noise_item();
						it.mode = MODE_READ;
						if ($urandom_range(0, 5) != 0) begin
							it.read_row = ($urandom_range(0, 1) == 0 && shadow_row < ROWS)
								? shadow_row[4:0] : 5'($urandom_range(0, ROWS - 1));
							it.read_col = 7'($urandom_range(0, COLUMNS - 1));
						end
						send_random(it);
					end
				end else if (kind == 16) begin
					it = noise_item();
					it.mode = MODE_CLEAR;
					send_random(it);
				end else if (kind == 17) begin
					it = noise_item();
					it.mode = MODE_NOP;
					send_random(it);
				end else begin
					repeat ($urandom_range(1, 5)) begin
						send_random(noise_item());
					end
				end
			end
		end
		start <= 1'b0;

		// drain, then watch for stray results over one full scroll
		while (pending_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat (NCELLS + 20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	task automatic check_field(input string fname, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			mismatch_count++;
		end
	endtask

	// compare each result with the oldest expected one
	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_cells.size() == 0) begin
				$error("result with no item pending");
				mismatch_count++;
			end else begin
				want = pending_cells.pop_front();
				check_field("cell_value", want.cell_value, cell_value);
				check_field("cell_row", 16'(want.cell_row), 16'(cell_row));
				check_field("cell_col", 16'(want.cell_col), 16'(cell_col));
				check_field("cell_valid", 16'(want.cell_valid), 16'(cell_valid));
				check_field("scrolled", 16'(want.scrolled), 16'(scrolled));
				check_field("cursor_row", 16'(want.cursor_row), 16'(cursor_row));
				check_field("cursor_col", 16'(want.cursor_col), 16'(cursor_col));
			end
		end
	end

	// watchdog: 100 ms, several times the slowest correct run
	initial begin
		#100_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
